[src/pps_pkg.sv]
package pps_pkg;

  // Field and state widths.
  localparam int IN_W   = 32;
  localparam int GAIN_W = 32;
  localparam int ERR_W  = IN_W + 1;
  localparam int DER_W  = ERR_W + 1;
  localparam int FRAC_W = 16;
  localparam int INT_W  = 50;
  localparam int X_W    = INT_W + 1;

  // Accumulator of the serial multiply: holds floor(sum / 2^GAIN_W) with headroom.
  localparam int MAC_W  = 54;

  // Leaky integral window and the radix-4 divider built around it.
  localparam int LEAK_WINDOW = 10;
  localparam int REM_W       = $clog2(LEAK_WINDOW + 1);
  localparam int T_W         = REM_W + 2;
  localparam int DIV_W       = X_W + (X_W % 2);
  localparam int DIV_STEPS   = DIV_W / 2;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  // Serial multiply: operand-sum precompute steps, then one gain bit per cycle.
  localparam int PREP_STEPS = 4;
  localparam int MAC_STEPS  = PREP_STEPS + GAIN_W;
  localparam int MCNT_W     = $clog2(MAC_STEPS);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_KP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POL = 8'd3;

  localparam logic signed [IN_W-1:0] DRIVE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [IN_W-1:0] DRIVE_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[src/pps_if.sv]
interface pps_sample_if;
  logic                            valid;
  logic                            ready;
  logic signed [pps_pkg::IN_W-1:0] setpoint;
  logic signed [pps_pkg::IN_W-1:0] position;
  logic                            restart;

  modport source (output valid, setpoint, position, restart, input ready);
  modport sink   (input valid, setpoint, position, restart, output ready);
endinterface

interface pps_result_if;
  logic                            valid;
  logic                            ready;
  logic signed [pps_pkg::IN_W-1:0] drive;
  logic                            saturated;

  modport source (output valid, drive, saturated, input ready);
  modport sink   (input valid, drive, saturated, output ready);
endinterface

interface pps_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [pps_pkg::CFG_IDX_W-1:0]        index;
  logic [pps_pkg::GAIN_W-1:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/pps_div10.sv]
module pps_div10 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [pps_pkg::X_W-1:0]    dividend,
  output logic signed [pps_pkg::X_W-1:0]    quot,
  output pps_pkg::unit_stat_t               stat
);

  localparam logic [pps_pkg::T_W-1:0] W1 = pps_pkg::T_W'(pps_pkg::LEAK_WINDOW);
  localparam logic [pps_pkg::T_W-1:0] W2 = pps_pkg::T_W'(2 * pps_pkg::LEAK_WINDOW);
  localparam logic [pps_pkg::T_W-1:0] W3 = pps_pkg::T_W'(3 * pps_pkg::LEAK_WINDOW);
  localparam logic [pps_pkg::DCNT_W-1:0] LAST = pps_pkg::DCNT_W'(pps_pkg::DIV_STEPS - 1);

  logic                              busy;
  logic                              fin;
  logic                              done;
  logic [pps_pkg::DCNT_W-1:0]        cnt;
  logic [pps_pkg::DIV_W-1:0]         sh;
  logic [pps_pkg::REM_W-1:0]         rem;
  logic                              neg;
  logic [pps_pkg::X_W-1:0]           mag;
  logic [pps_pkg::T_W-1:0]           t;
  logic [1:0]                        digit;
  logic [pps_pkg::T_W-1:0]           t_sub;

  assign mag = dividend[pps_pkg::X_W-1] ? (~dividend + 1'b1) : dividend;

  // Two dividend bits enter the partial remainder each cycle; the quotient digit
  // is found by comparing against one, two and three times the divisor.
  assign t = {rem, sh[pps_pkg::DIV_W-1 -: 2]};

  always_comb begin
    if (t >= W3) begin
      digit = 2'd3;
      t_sub = t - W3;
    end else if (t >= W2) begin
      digit = 2'd2;
      t_sub = t - W2;
    end else if (t >= W1) begin
      digit = 2'd1;
      t_sub = t - W1;
    end else begin
      digit = 2'd0;
      t_sub = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= pps_pkg::DIV_W'(mag);
      rem <= '0;
      cnt <= '0;
      neg <= dividend[pps_pkg::X_W-1];
    end else if (busy) begin
      sh  <= {sh[pps_pkg::DIV_W-3:0], digit};
      rem <= t_sub[pps_pkg::REM_W-1:0];
      cnt <= cnt + 1'b1;
    end else if (fin) begin
      // Truncation toward zero: divide the magnitude, then restore the sign.
      quot <= neg ? -$signed(sh[pps_pkg::X_W-1:0]) : $signed(sh[pps_pkg::X_W-1:0]);
    end
  end

  assign stat.busy = busy | fin;
  assign stat.done = done;

endmodule

[src/pps_mac.sv]
module pps_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [pps_pkg::GAIN_W-1:0]   kp,
  input  logic signed [pps_pkg::GAIN_W-1:0]   kd,
  input  logic signed [pps_pkg::GAIN_W-1:0]   ki,
  input  logic signed [pps_pkg::MAC_W-1:0]    opa,
  input  logic signed [pps_pkg::MAC_W-1:0]    opb,
  input  logic signed [pps_pkg::MAC_W-1:0]    opc,
  output logic signed [pps_pkg::MAC_W-1:0]    acc,
  output logic                                sticky,
  output pps_pkg::unit_stat_t                 stat
);

  localparam logic [pps_pkg::MCNT_W-1:0] PREP_END = pps_pkg::MCNT_W'(pps_pkg::PREP_STEPS);
  localparam logic [pps_pkg::MCNT_W-1:0] LAST     = pps_pkg::MCNT_W'(pps_pkg::MAC_STEPS - 1);

  logic                              busy;
  logic                              done;
  logic [pps_pkg::MCNT_W-1:0]        cnt;
  logic [pps_pkg::GAIN_W-1:0]        gp;
  logic [pps_pkg::GAIN_W-1:0]        gd;
  logic [pps_pkg::GAIN_W-1:0]        gi;
  logic signed [pps_pkg::MAC_W-1:0]  c_a;
  logic signed [pps_pkg::MAC_W-1:0]  c_b;
  logic signed [pps_pkg::MAC_W-1:0]  c_c;
  logic signed [pps_pkg::MAC_W-1:0]  c_ab;
  logic signed [pps_pkg::MAC_W-1:0]  c_ac;
  logic signed [pps_pkg::MAC_W-1:0]  c_bc;
  logic signed [pps_pkg::MAC_W-1:0]  c_abc;
  logic signed [pps_pkg::MAC_W-1:0]  add_x;
  logic signed [pps_pkg::MAC_W-1:0]  add_y;
  logic signed [pps_pkg::MAC_W-1:0]  add_s;
  logic signed [pps_pkg::MAC_W-1:0]  pick;
  logic signed [pps_pkg::MAC_W-1:0]  step_s;
  logic                              in_prep;
  logic                              last_bit;

  assign in_prep  = (cnt < PREP_END);
  assign last_bit = (cnt == LAST);

  // One shared adder builds the sums of operand pairs and of all three.
  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        add_x = c_a;
        add_y = c_b;
      end
      2'd1: begin
        add_x = c_a;
        add_y = c_c;
      end
      2'd2: begin
        add_x = c_b;
        add_y = c_c;
      end
      default: begin
        add_x = c_ab;
        add_y = c_c;
      end
    endcase
  end
  assign add_s = add_x + add_y;

  always_comb begin
    case ({gi[0], gd[0], gp[0]})
      3'b001:  pick = c_a;
      3'b010:  pick = c_b;
      3'b011:  pick = c_ab;
      3'b100:  pick = c_c;
      3'b101:  pick = c_ac;
      3'b110:  pick = c_bc;
      3'b111:  pick = c_abc;
      default: pick = '0;
    endcase
  end

  // The top gain bit carries negative weight in two's complement.
  assign step_s = last_bit ? (acc - pick) : (acc + pick);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && last_bit) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      c_a    <= opa;
      c_b    <= opb;
      c_c    <= opc;
      gp     <= kp;
      gd     <= kd;
      gi     <= ki;
      acc    <= '0;
      sticky <= 1'b0;
      cnt    <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (in_prep) begin
        case (cnt[1:0])
          2'd0:    c_ab  <= add_s;
          2'd1:    c_ac  <= add_s;
          2'd2:    c_bc  <= add_s;
          default: c_abc <= add_s;
        endcase
      end else begin
        // Bits shifted out are the fraction below 2^-32; only whether any was set matters.
        acc    <= step_s >>> 1;
        sticky <= sticky | step_s[0];
        gp     <= gp >> 1;
        gd     <= gd >> 1;
        gi     <= gi >> 1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[src/pid_position_step.sv]
// Channel   Dir  Payload                                  Transfer when
// sample    in   setpoint[31:0], position[31:0], restart  valid && ready
// result    out  drive[31:0], saturated                   valid && ready
// cfg       in   index[7:0], data[31:0]                   valid && ready (ready is always high)
//
// One item at a time: a normal result passes through dividend set-up, a radix-4 divide by the
// leak window in 26 steps plus start, sign and hand-off, the integral update, a bit-serial
// multiply of operand-sum set-up steps and 32 gain bits, and the output load; the next sample
// can transfer only after that load. A restart result skips straight to the output load.
// rst is synchronous and active high; it clears the gains, the integral and the previous error
// and sets polarity to 1. A stalled result holds the engine only once the next result is ready
// to be written.
module pid_position_step (
  input  logic          clk,
  input  logic          rst,
  pps_sample_if.sink    sample,
  pps_result_if.source  result,
  pps_cfg_if.sink       cfg
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PREP = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_UPD  = 6'b001000,
    ST_MAC  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t                                 state;
  logic signed [pps_pkg::GAIN_W-1:0]      kp_gain;
  logic signed [pps_pkg::GAIN_W-1:0]      ki_gain;
  logic signed [pps_pkg::GAIN_W-1:0]      kd_gain;
  logic                                   polarity;
  logic signed [pps_pkg::INT_W-1:0]       integ;
  logic signed [pps_pkg::ERR_W-1:0]       last_err;
  logic signed [pps_pkg::ERR_W-1:0]       err;
  logic signed [pps_pkg::DER_W-1:0]       deriv;
  logic signed [pps_pkg::X_W-1:0]         xdiv;
  logic                                   clr;
  logic                                   div_start;
  logic                                   mac_start;
  logic                                   res_valid;
  logic signed [pps_pkg::IN_W-1:0]        res_drive;
  logic                                   res_sat;

  logic signed [pps_pkg::X_W-1:0]         delta;
  logic signed [pps_pkg::MAC_W-1:0]       acc;
  logic                                   sticky;
  pps_pkg::unit_stat_t                    div_st;
  pps_pkg::unit_stat_t                    mac_st;
  logic signed [pps_pkg::MAC_W-1:0]       opa;
  logic signed [pps_pkg::MAC_W-1:0]       opb;
  logic signed [pps_pkg::MAC_W-1:0]       opc;
  logic signed [pps_pkg::X_W-1:0]         integ_sum;
  logic signed [pps_pkg::MAC_W-1:0]       q;
  logic                                   hi_ones;
  logic                                   hi_zeros;
  logic signed [pps_pkg::IN_W-1:0]        drive_val;
  logic                                   sat_val;
  logic                                   accept;
  logic                                   fin_load;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == ST_IDLE);
  assign accept       = sample.valid && sample.ready;
  assign fin_load     = (state == ST_FIN) && (!res_valid || result.ready);

  assign result.valid     = res_valid;
  assign result.drive     = res_drive;
  assign result.saturated = res_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain  <= '0;
      ki_gain  <= '0;
      kd_gain  <= '0;
      polarity <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        pps_pkg::REG_KP:  kp_gain  <= cfg.data;
        pps_pkg::REG_KI:  ki_gain  <= cfg.data;
        pps_pkg::REG_KD:  kd_gain  <= cfg.data;
        pps_pkg::REG_POL: polarity <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Error and derivative carry 16 fraction bits into the multiply; the integral has them.
  assign opa = {{(pps_pkg::MAC_W - pps_pkg::ERR_W - pps_pkg::FRAC_W){err[pps_pkg::ERR_W-1]}},
                err, {pps_pkg::FRAC_W{1'b0}}};
  assign opb = {{(pps_pkg::MAC_W - pps_pkg::DER_W - pps_pkg::FRAC_W){deriv[pps_pkg::DER_W-1]}},
                deriv, {pps_pkg::FRAC_W{1'b0}}};
  assign opc = {{(pps_pkg::MAC_W - pps_pkg::INT_W){integ[pps_pkg::INT_W-1]}}, integ};

  assign integ_sum = {integ[pps_pkg::INT_W-1], integ} + delta;

  pps_div10 u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (xdiv),
    .quot     (delta),
    .stat     (div_st)
  );

  pps_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .start  (mac_start),
    .kp     (kp_gain),
    .kd     (kd_gain),
    .ki     (ki_gain),
    .opa    (opa),
    .opb    (opb),
    .opc    (opc),
    .acc    (acc),
    .sticky (sticky),
    .stat   (mac_st)
  );

  // Negating before the floor: -floor-of-negated equals ~acc plus one unless fraction bits
  // were shifted out.
  assign q = polarity ? acc : (~acc + {{(pps_pkg::MAC_W-1){1'b0}}, ~sticky});

  assign hi_ones  = &q[pps_pkg::MAC_W-1:pps_pkg::IN_W-1];
  assign hi_zeros = ~|q[pps_pkg::MAC_W-1:pps_pkg::IN_W-1];

  always_comb begin
    if (clr) begin
      drive_val = '0;
      sat_val   = 1'b0;
    end else if (q[pps_pkg::MAC_W-1] && !hi_ones) begin
      drive_val = pps_pkg::DRIVE_MIN;
      sat_val   = 1'b1;
    end else if (!q[pps_pkg::MAC_W-1] && !hi_zeros) begin
      drive_val = pps_pkg::DRIVE_MAX;
      sat_val   = 1'b1;
    end else begin
      drive_val = q[pps_pkg::IN_W-1:0];
      sat_val   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      integ     <= '0;
      last_err  <= '0;
      div_start <= 1'b0;
      mac_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mac_start <= 1'b0;
      if (fin_load) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (sample.restart) begin
              integ    <= '0;
              last_err <= '0;
              state    <= ST_FIN;
            end else begin
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          div_start <= 1'b1;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_st.done) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          integ     <= integ_sum[pps_pkg::INT_W-1:0];
          last_err  <= err;
          mac_start <= 1'b1;
          state     <= ST_MAC;
        end
        ST_MAC: begin
          if (mac_st.done) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clr <= sample.restart;
      err <= {sample.setpoint[pps_pkg::IN_W-1], sample.setpoint}
           - {sample.position[pps_pkg::IN_W-1], sample.position};
    end
    if (state == ST_PREP) begin
      deriv <= {err[pps_pkg::ERR_W-1], err} - {last_err[pps_pkg::ERR_W-1], last_err};
      xdiv  <= {{(pps_pkg::X_W - pps_pkg::ERR_W - pps_pkg::FRAC_W){err[pps_pkg::ERR_W-1]}},
                err, {pps_pkg::FRAC_W{1'b0}}}
             - {integ[pps_pkg::INT_W-1], integ};
    end
    if (fin_load) begin
      res_drive <= drive_val;
      res_sat   <= sat_val;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    sample.ready |-> (!div_st.busy && !mac_st.busy))
    else $error("input ready while an arithmetic unit is busy");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && sample.restart) |=> (integ == '0 && last_err == '0))
    else $error("restart did not clear the controller state");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_sat) |-> (res_drive == pps_pkg::DRIVE_MAX
                                || res_drive == pps_pkg::DRIVE_MIN))
    else $error("saturation flagged on a drive that is not at a limit");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide phase");

  a_mac_done_state: assert property (@(posedge clk) disable iff (rst)
    mac_st.done |-> (state == ST_MAC))
    else $error("multiply finished outside the multiply phase");

endmodule
